@@ hw/rtl/iee_pkg.sv @@
// shared types, constants and the direction code table of the input edge event recorder
package iee_pkg;

	localparam int AXIS_W   = 16;
	localparam int MASK_W   = 10;
	localparam int DIR_W    = 4;
	localparam int BTN_N    = 6;
	localparam int ID_W     = 4;
	localparam int EVT_MAX  = 7;
	localparam int EVT_CW   = 3;
	localparam int PACK_N   = 10;
	localparam int PACK_W   = PACK_N * ID_W;
	localparam int LEN_W    = 4;
	localparam int IN_W     = 8 * AXIS_W;
	localparam int OUT_W    = 64;

	localparam logic [ID_W-1:0] BTN_ID_BASE = 4'd8;

	typedef struct packed {
		logic [EVT_CW-1:0]            count;
		logic [EVT_MAX-1:0][ID_W-1:0] ids;
	} evt_t;

	typedef struct packed {
		logic            hit;
		logic [ID_W-1:0] id;
	} dir_hit_t;

	// direction code to event id, hit clear for codes that are not events
	function automatic dir_hit_t dir_lookup(input logic [DIR_W-1:0] code);
		dir_hit_t r;
		r.hit = 1'b1;
		unique case (code)
			4'd5:    r.id = 4'd4;
			4'd1:    r.id = 4'd0;
			4'd9:    r.id = 4'd5;
			4'd4:    r.id = 4'd2;
			4'd8:    r.id = 4'd3;
			4'd6:    r.id = 4'd7;
			4'd2:    r.id = 4'd1;
			4'd10:   r.id = 4'd6;
			default: begin
				r.hit = 1'b0;
				r.id  = '0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/iee_decode.sv @@
// pressed mask from the raw frame and in-order list of newly entered events
module iee_decode (
	input  logic [iee_pkg::IN_W-1:0]   frame,
	input  logic [iee_pkg::MASK_W-1:0] prev_mask,
	input  logic                       record_enable,
	output logic [iee_pkg::MASK_W-1:0] mask,
	output iee_pkg::evt_t              evt
);

	logic [7:0][iee_pkg::AXIS_W-1:0] val;
	logic [7:0]                      neg;
	logic [7:0]                      pos;
	iee_pkg::dir_hit_t               dir_now;
	logic [iee_pkg::EVT_CW-1:0]      cnt;

	assign val = frame;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			neg[k] = val[k][iee_pkg::AXIS_W-1];
			pos[k] = (val[k] != '0) && !val[k][iee_pkg::AXIS_W-1];
		end
		mask[0] = neg[0];
		mask[1] = pos[0];
		mask[2] = neg[1];
		mask[3] = pos[1];
		for (int b = 0; b < iee_pkg::BTN_N; b++) begin
			mask[iee_pkg::DIR_W+b] = pos[2+b];
		end
	end

	assign dir_now = iee_pkg::dir_lookup(mask[iee_pkg::DIR_W-1:0]);

	// direction event first, then buttons in order, packed from slot 0
	always_comb begin
		cnt     = '0;
		evt.ids = '0;
		if (dir_now.hit && (prev_mask[iee_pkg::DIR_W-1:0] != mask[iee_pkg::DIR_W-1:0])) begin
			evt.ids[cnt] = dir_now.id;
			cnt          = cnt + 3'd1;
		end
		for (int b = 0; b < iee_pkg::BTN_N; b++) begin
			if (mask[iee_pkg::DIR_W+b] && !prev_mask[iee_pkg::DIR_W+b]) begin
				evt.ids[cnt] = iee_pkg::BTN_ID_BASE + iee_pkg::ID_W'(b);
				cnt          = cnt + 3'd1;
			end
		end
		evt.count = record_enable ? cnt : '0;
	end

endmodule

@@ hw/rtl/iee_history.sv @@
// event history kept oldest first, appended per beat, packed for output
module iee_history #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  iee_pkg::evt_t              evt,
	output logic [iee_pkg::PACK_W-1:0] history_packed,
	output logic [iee_pkg::LEN_W-1:0]  history_length
);

	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = $clog2(HISTORY_DEPTH + 8);
	localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int PACK_D = (HISTORY_DEPTH < iee_pkg::PACK_N) ? HISTORY_DEPTH : iee_pkg::PACK_N;

	logic [HISTORY_DEPTH-1:0][iee_pkg::ID_W-1:0] hist_q;
	logic [HISTORY_DEPTH-1:0][iee_pkg::ID_W-1:0] hist_nxt;
	logic [CNT_W-1:0]                            cnt_q;
	logic [CNT_W-1:0]                            cnt_nxt;
	logic [SUM_W-1:0]                            total;
	logic [SUM_W-1:0]                            drop;
	logic [SUM_W-1:0]                            pos;
	logic [SUM_W-1:0]                            ev_pos;

	assign total = SUM_W'(cnt_q) + SUM_W'(evt.count);

	// oldest entries fall off the front when the history overflows
	always_comb begin
		drop    = '0;
		cnt_nxt = CNT_W'(total);
		if (total > SUM_W'(HISTORY_DEPTH)) begin
			drop    = total - SUM_W'(HISTORY_DEPTH);
			cnt_nxt = CNT_W'(HISTORY_DEPTH);
		end
	end

	always_comb begin
		pos    = '0;
		ev_pos = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			pos    = SUM_W'(i) + drop;
			ev_pos = pos - SUM_W'(cnt_q);
			if (pos < SUM_W'(cnt_q)) begin
				hist_nxt[i] = hist_q[pos[IDX_W-1:0]];
			end else begin
				hist_nxt[i] = evt.ids[ev_pos[iee_pkg::EVT_CW-1:0]];
			end
		end
	end

	always_comb begin
		history_packed = '0;
		for (int i = 0; i < PACK_D; i++) begin
			if (CNT_W'(i) < cnt_nxt) begin
				history_packed[i*iee_pkg::ID_W +: iee_pkg::ID_W] = hist_nxt[i];
			end
		end
	end

	assign history_length = iee_pkg::LEN_W'(cnt_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hist_q <= hist_nxt;
		end
	end

endmodule

@@ hw/rtl/input_edge_event_recorder.sv @@
// top level: input register, edge decode, history update and result register
// pipeline: two register stages, the input register and then the result register that drives m_axis_tvalid
// throughput: one beat per cycle while m_axis_tready is high, set by the single decode and history update stage
// while a result waits for m_axis_tready the input register still takes one more beat
// reset clears record_enable, the previous mask, the history length and both valid flags
module input_edge_event_recorder #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// axis_vertical, axis_horizontal, button_a, button_b, button_c, button_d,
	// button_change, button_special, 16 bits each
	input  logic [iee_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// pressed_mask, history_packed, history_length, new_event_count, zero pad
	output logic [iee_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int RES_W = iee_pkg::MASK_W + iee_pkg::PACK_W + iee_pkg::LEN_W + iee_pkg::EVT_CW;

	logic                       record_enable_q;
	logic                       valid_s1;
	logic [iee_pkg::IN_W-1:0]   frame_s1;
	logic [iee_pkg::MASK_W-1:0] prev_mask_q;
	logic                       out_valid_q;
	logic [RES_W-1:0]           result_q;
	logic                       advance;
	logic                       in_beat;
	logic [iee_pkg::MASK_W-1:0] mask;
	iee_pkg::evt_t              evt;
	logic [iee_pkg::PACK_W-1:0] history_packed;
	logic [iee_pkg::LEN_W-1:0]  history_length;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	iee_decode u_decode (
		.frame         (frame_s1),
		.prev_mask     (prev_mask_q),
		.record_enable (record_enable_q),
		.mask          (mask),
		.evt           (evt)
	);

	iee_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.evt            (evt),
		.history_packed (history_packed),
		.history_length (history_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_enable_q <= 1'b0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			prev_mask_q     <= '0;
		end else begin
			if (cfg_we) begin
				record_enable_q <= cfg_wdata;
			end
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				prev_mask_q <= mask;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			frame_s1 <= s_axis_tdata;
		end
		if (advance) begin
			result_q <= {evt.count, history_length, history_packed, mask};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = iee_pkg::OUT_W'(result_q);

endmodule

@@ dv/input_edge_event_recorder_tb.sv @@
// testbench for the input edge event recorder: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module input_edge_event_recorder_tb;
	import iee_pkg::*;

	localparam int HIST_DEPTH     = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 100;
	localparam int PAD_W          = OUT_W - EVT_CW - LEN_W - PACK_W - MASK_W;

	// direction codes, as held in the low nibble of the mask
	localparam logic [DIR_W-1:0] DIR_NONE  = 4'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 4'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 4'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 4'd4;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 4'd8;

	typedef enum logic [ID_W-1:0] {
		EV_UP, EV_DOWN, EV_LEFT, EV_RIGHT,
		EV_UP_LEFT, EV_UP_RIGHT, EV_DOWN_RIGHT, EV_DOWN_LEFT
	} dir_event_t;

	// first declared field sits in the highest bits
	typedef struct packed {
		logic signed [AXIS_W-1:0] btn_special;
		logic signed [AXIS_W-1:0] btn_change;
		logic signed [AXIS_W-1:0] btn_d;
		logic signed [AXIS_W-1:0] btn_c;
		logic signed [AXIS_W-1:0] btn_b;
		logic signed [AXIS_W-1:0] btn_a;
		logic signed [AXIS_W-1:0] axis_h;
		logic signed [AXIS_W-1:0] axis_v;
	} frame_t;

	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [EVT_CW-1:0] new_count;
		logic [LEN_W-1:0]  hist_len;
		logic [PACK_W-1:0] history;
		logic [MASK_W-1:0] mask;
	} recorder_out_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;

	input_edge_event_recorder #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// predictor state
	bit                record_on = 1'b0;
	logic [MASK_W-1:0] prev_mask = '0;
	logic [ID_W-1:0]   history_ring [HIST_DEPTH];
	int                ring_start = 0;
	int                ring_count = 0;

	recorder_out_t     expected_results [$];
	frame_t            last_frame = '0;
	bit                gaps_on = 1'b1;

	int frames_sent     = 0;
	int results_checked = 0;
	int events_recorded = 0;
	int ring_overwrites = 0;
	int mismatch_count  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_event(logic [ID_W-1:0] id);
		history_ring[(ring_start + ring_count) % HIST_DEPTH] = id;
		if (ring_count >= HIST_DEPTH) begin
			ring_start = (ring_start + 1) % HIST_DEPTH;
			ring_overwrites++;
		end else begin
			ring_count++;
		end
	endfunction

	function automatic recorder_out_t predict_frame(frame_t f);
		recorder_out_t            r;
		logic [MASK_W-1:0]        now;
		logic [DIR_W-1:0]         dir_now;
		logic signed [AXIS_W-1:0] btn [BTN_N];
		logic [ID_W-1:0]          dir_id;
		bit                       dir_hit;
		int                       pushed;
		btn = '{f.btn_a, f.btn_b, f.btn_c, f.btn_d, f.btn_change, f.btn_special};
		now = '0;
		pushed = 0;
		now[0] = $signed(f.axis_v) < 0;
		now[1] = $signed(f.axis_v) > 0;
		now[2] = $signed(f.axis_h) < 0;
		now[3] = $signed(f.axis_h) > 0;
		for (int i = 0; i < BTN_N; i++)
			now[DIR_W+i] = btn[i] > 0;
		dir_now = now[DIR_W-1:0];
		if (record_on) begin
			dir_hit = 1'b1;
			dir_id = '0;
			case (dir_now)
				DIR_UP | DIR_LEFT:    dir_id = EV_UP_LEFT;
				DIR_UP:               dir_id = EV_UP;
				DIR_UP | DIR_RIGHT:   dir_id = EV_UP_RIGHT;
				DIR_LEFT:             dir_id = EV_LEFT;
				DIR_RIGHT:            dir_id = EV_RIGHT;
				DIR_DOWN | DIR_LEFT:  dir_id = EV_DOWN_LEFT;
				DIR_DOWN:             dir_id = EV_DOWN;
				DIR_DOWN | DIR_RIGHT: dir_id = EV_DOWN_RIGHT;
				default:              dir_hit = 1'b0;
			endcase
			// a direction only fires on entering a new code
			if (dir_hit && dir_now != prev_mask[DIR_W-1:0]) begin
				push_event(dir_id);
				pushed++;
			end
			for (int i = 0; i < BTN_N; i++) begin
				if (now[DIR_W+i] && !prev_mask[DIR_W+i]) begin
					push_event(ID_W'(BTN_ID_BASE + i));
					pushed++;
				end
			end
		end
		prev_mask = now;
		r = '0;
		r.mask = now;
		for (int i = 0; i < ring_count && i < PACK_N; i++)
			r.history[i*ID_W +: ID_W] = history_ring[(ring_start + i) % HIST_DEPTH];
		r.hist_len = LEN_W'(ring_count);
		r.new_count = EVT_CW'(pushed);
		events_recorded += pushed;
		return r;
	endfunction

	function automatic logic signed [AXIS_W-1:0] magnitude(bit negative);
		if (negative)
			return AXIS_W'(-int'($urandom_range(1, 32768)));
		return AXIS_W'($urandom_range(1, 32767));
	endfunction

	// frame with the given direction code and pressed buttons, other values random
	function automatic frame_t dir_frame(logic [DIR_W-1:0] code, logic [BTN_N-1:0] presses);
		frame_t                   f;
		logic signed [AXIS_W-1:0] b [BTN_N];
		for (int i = 0; i < BTN_N; i++)
			b[i] = presses[i] ? magnitude(1'b0) : ($urandom_range(0, 1) ? magnitude(1'b1) : '0);
		f.axis_v = (code & DIR_UP) != 0 ? magnitude(1'b1) :
			(code & DIR_DOWN) != 0 ? magnitude(1'b0) : '0;
		f.axis_h = (code & DIR_LEFT) != 0 ? magnitude(1'b1) :
			(code & DIR_RIGHT) != 0 ? magnitude(1'b0) : '0;
		f.btn_a = b[0];
		f.btn_b = b[1];
		f.btn_c = b[2];
		f.btn_d = b[3];
		f.btn_change = b[4];
		f.btn_special = b[5];
		return f;
	endfunction

	function automatic logic signed [AXIS_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'sd1;
			2: return -16'sd1;
			3: return 16'sh7fff;
			4: return 16'sh8000;
			5: return AXIS_W'($urandom_range(1, 300));
			6: return AXIS_W'(-int'($urandom_range(1, 300)));
			default: return AXIS_W'($urandom());
		endcase
	endfunction

	// holding values often lets presses persist so releases and re-presses show up
	function automatic logic signed [AXIS_W-1:0] next_value(logic signed [AXIS_W-1:0] prev);
		return ($urandom_range(0, 99) < 45) ? prev : rand_value();
	endfunction

	task automatic send_frame(input frame_t f);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		expected_results.push_back(predict_frame(f));
		last_frame = f;
		frames_sent++;
	endtask

	// register writes only once every result is out
	task automatic set_record(input bit en);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		record_on = en;
	endtask

	task automatic test_disabled_extremes();
		logic signed [AXIS_W-1:0] vals [5];
		vals = '{16'sd0, 16'sd1, -16'sd1, 16'sh7fff, 16'sh8000};
		foreach (vals[i])
			send_frame({8{vals[i]}});
	endtask

	task automatic test_direction_codes();
		logic [DIR_W-1:0] walk [10];
		walk = '{DIR_NONE, DIR_UP | DIR_LEFT, DIR_UP | DIR_LEFT, DIR_UP, DIR_UP | DIR_RIGHT,
			DIR_LEFT, DIR_RIGHT, DIR_DOWN | DIR_LEFT, DIR_DOWN, DIR_DOWN | DIR_RIGHT};
		set_record(1'b1);
		foreach (walk[i])
			send_frame(dir_frame(walk[i], '0));
	endtask

	// seven events in one frame, pushing the ring past full
	task automatic test_all_buttons_wrap();
		send_frame(dir_frame(DIR_NONE, '0));
		send_frame(dir_frame(DIR_DOWN | DIR_RIGHT, '1));
		send_frame(dir_frame(DIR_DOWN | DIR_RIGHT, '1));
		send_frame(dir_frame(DIR_DOWN | DIR_RIGHT, '0));
		send_frame(dir_frame(DIR_UP, '1));
	endtask

	task automatic test_random_frames(input int count);
		frame_t f;
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) begin
				f = '0;
			end else begin
				f.axis_v = next_value(last_frame.axis_v);
				f.axis_h = next_value(last_frame.axis_h);
				f.btn_a = next_value(last_frame.btn_a);
				f.btn_b = next_value(last_frame.btn_b);
				f.btn_c = next_value(last_frame.btn_c);
				f.btn_d = next_value(last_frame.btn_d);
				f.btn_change = next_value(last_frame.btn_change);
				f.btn_special = next_value(last_frame.btn_special);
			end
			send_frame(f);
		end
	endtask

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
	endtask

	// result side: random stalls before each beat while gaps_on is set
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		recorder_out_t got;
		recorder_out_t want;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			got = m_axis_tdata;
			if (expected_results.size() == 0) begin
				report("unexpected beat", '0, got);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got.mask !== want.mask)
					report("pressed_mask", want.mask, got.mask);
				if (got.history !== want.history)
					report("history_packed", want.history, got.history);
				if (got.hist_len !== want.hist_len)
					report("history_length", want.hist_len, got.hist_len);
				if (got.new_count !== want.new_count)
					report("new_event_count", want.new_count, got.new_count);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_extremes();
		test_direction_codes();
		test_all_buttons_wrap();

		gaps_on = 1'b1;
		set_record(1'b1);
		test_random_frames(450);
		set_record(1'b0);
		test_random_frames(250);
		set_record(1'b1);
		gaps_on = 1'b0;
		test_random_frames(300);
		gaps_on = 1'b1;
		test_random_frames(400);
		set_record(1'b0);
		set_record(1'b1);
		test_random_frames(350);

		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("covered %0d frames and %0d results, recording switched on and off",
			frames_sent, results_checked);
		$display("%0d events went into the history, %0d of them over the oldest entry",
			events_recorded, ring_overwrites);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
